[rtl/tms_pkg.sv]
// tms_pkg: shared types and constants for the tree merge similarity block.
// No dependencies; imported by the interfaces and the top level.
package tms_pkg;

    localparam int NODE_W  = 12;
    localparam int VAL_W   = 16;
    localparam int DIST_W  = 16;
    localparam int WGT_W   = 17;
    localparam int PROD_W  = VAL_W + WGT_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SUM_W   = 20;
    localparam int NODES   = 4096;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_MERGE  = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX  = 20'hFFFFF;
    localparam logic [VAL_W-1:0] ONE_Q15  = 16'd32768;
    localparam logic [VAL_W-1:0] NODE_MAX = 16'hFFFF;
    localparam logic [WGT_W-1:0] WGT_ONE  = 17'h10000;
    localparam logic [ACC_W-1:0] ROUND_HALF = 34'd32768;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDL  = 9'b000000010,
        S_RDR  = 9'b000000100,
        S_RDP  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_WR   = 9'b000100000,
        S_FRD  = 9'b001000000,
        S_FSUM = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

endpackage

[rtl/tms_if.sv]
// tms_if: valid/ready channel interfaces for request and result items.
// Depends on tms_pkg for field widths.
interface tms_req_if import tms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [NODE_W-1:0] node_index;
    logic [VAL_W-1:0]  value_a;
    logic [VAL_W-1:0]  value_b;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic [NODE_W-1:0] parent_node;
    logic [DIST_W-1:0] left_distance;
    logic [DIST_W-1:0] right_distance;

    modport source (output valid, action, node_index, value_a, value_b, left_child,
                    right_child, parent_node, left_distance, right_distance,
                    input ready);
    modport sink   (input valid, action, node_index, value_a, value_b, left_child,
                    right_child, parent_node, left_distance, right_distance,
                    output ready);
endinterface

interface tms_res_if import tms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] similarity;

    modport source (output valid, similarity, input ready);
    modport sink   (input valid, similarity, output ready);
endinterface

[rtl/tree_merge_similarity_top.sv]
// A load is written to the node store as it is accepted; a merge does three reads on the
// node store port, four products through one shared 16x17 multiplier, one write.
// A finish request passes S_FRD, then S_FSUM, which waits until the output register is free.
// Throughput: 1 load per cycle while idle; a merge or finish blocks new requests until done.
// Synchronous active-low reset clears the sequencer, the running sum and the last parent;
// node stores are not cleared and read as undefined until loaded.
module tree_merge_similarity_top import tms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tms_req_if.sink    i_req,
    tms_res_if.source  o_res
);

    t_state r_state, n_state;
    logic [2:0] r_cnt;

    logic [NODE_W-1:0] r_l, r_r, r_p, r_last;
    logic [WGT_W-1:0]  r_wl, r_wr;
    logic [VAL_W-1:0]  r_al, r_bl, r_ar, r_br;
    logic [VAL_W-1:0]  r_rd_a, r_rd_b;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc_a, r_acc_b;
    logic [SUM_W-1:0]  r_sum;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;

    logic [VAL_W-1:0] mem_a [NODES];
    logic [VAL_W-1:0] mem_b [NODES];

    logic              req_acc, out_free;
    logic [NODE_W-1:0] rd_addr, wr_addr;
    logic              wr_en;
    logic [VAL_W-1:0]  wr_a, wr_b;
    logic [VAL_W-1:0]  ml, mr, fmin;
    logic [VAL_W-1:0]  lft_al, lft_ar, lft_bl, lft_br;
    logic [VAL_W-1:0]  mul_x;
    logic [WGT_W-1:0]  mul_y;
    logic [SUM_W:0]    msum, fsum;
    logic [SUM_W-1:0]  fsat;
    logic [VAL_W+2:0]  nv_a, nv_b;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.similarity = r_out_data;

    // min and leftover per child
    assign ml = (r_al < r_bl) ? r_al : r_bl;
    assign mr = (r_ar < r_br) ? r_ar : r_br;
    assign lft_al = r_al - ml;
    assign lft_bl = r_bl - ml;
    assign lft_ar = r_ar - mr;
    assign lft_br = r_br - mr;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mul_x = lft_al; mul_y = r_wl; end
            2'd1:    begin mul_x = lft_ar; mul_y = r_wr; end
            2'd2:    begin mul_x = lft_bl; mul_y = r_wl; end
            default: begin mul_x = lft_br; mul_y = r_wr; end
        endcase
    end

    assign msum = {1'b0, r_sum} + {4'b0, {1'b0, ml} + {1'b0, mr}};
    assign fmin = (r_rd_a < r_rd_b) ? r_rd_a : r_rd_b;
    assign fsum = {1'b0, r_sum} + {5'b0, fmin};
    assign fsat = fsum[SUM_W] ? SUM_MAX : fsum[SUM_W-1:0];

    assign nv_a = {3'b0, r_rd_a} + {1'b0, r_acc_a[ACC_W-1:16]};
    assign nv_b = {3'b0, r_rd_b} + {1'b0, r_acc_b[ACC_W-1:16]};

    always_comb begin
        case (r_state)
            S_RDL:        rd_addr = r_l;
            S_RDR:        rd_addr = r_r;
            S_FRD, S_FSUM: rd_addr = r_last;
            default:      rd_addr = r_p;
        endcase
    end

    always_comb begin
        if (r_state == S_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_p;
            wr_a    = (nv_a > {3'b0, NODE_MAX}) ? NODE_MAX : nv_a[VAL_W-1:0];
            wr_b    = (nv_b > {3'b0, NODE_MAX}) ? NODE_MAX : nv_b[VAL_W-1:0];
        end else begin
            wr_en   = req_acc && (i_req.action == ACT_LOAD);
            wr_addr = i_req.node_index;
            wr_a    = i_req.value_a;
            wr_b    = i_req.value_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
        end
        r_rd_a <= mem_a[rd_addr];
        r_rd_b <= mem_b[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc && i_req.action == ACT_MERGE) n_state = S_RDL;
                else if (req_acc && i_req.action == ACT_FINISH) n_state = S_FRD;
            end
            S_RDL:  n_state = S_RDR;
            S_RDR:  n_state = S_RDP;
            S_RDP:  n_state = S_MUL;
            S_MUL:  if (r_cnt == 3'd4) n_state = S_WR;
            S_WR:   n_state = S_IDLE;
            S_FRD:  n_state = S_FSUM;
            S_FSUM: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd0;
            r_sum       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == S_MUL) ? r_cnt + 3'd1 : 3'd0;
            if (r_state == S_MUL && r_cnt == 3'd0)
                r_sum <= msum[SUM_W] ? SUM_MAX : msum[SUM_W-1:0];
            if (r_state == S_WR)
                r_last <= r_p;
            if (r_state == S_FSUM && out_free) begin
                r_sum       <= '0;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_l  <= i_req.left_child;
            r_r  <= i_req.right_child;
            r_p  <= i_req.parent_node;
            r_wl <= WGT_ONE - {1'b0, i_req.left_distance};
            r_wr <= WGT_ONE - {1'b0, i_req.right_distance};
        end
        if (r_state == S_RDR) begin
            r_al <= r_rd_a;
            r_bl <= r_rd_b;
        end
        if (r_state == S_RDP) begin
            r_ar <= r_rd_a;
            r_br <= r_rd_b;
        end
        r_prod <= {{WGT_W{1'b0}}, mul_x} * {{VAL_W{1'b0}}, mul_y};
        if (r_state == S_MUL) begin
            case (r_cnt)
                3'd1:    r_acc_a <= ROUND_HALF + {1'b0, r_prod};
                3'd2:    r_acc_a <= r_acc_a + {1'b0, r_prod};
                3'd3:    r_acc_b <= ROUND_HALF + {1'b0, r_prod};
                3'd4:    r_acc_b <= r_acc_b + {1'b0, r_prod};
                default: ;
            endcase
        end
        if (r_state == S_FSUM && out_free)
            r_out_data <= (fsat > {4'b0, ONE_Q15}) ? ONE_Q15 : fsat[VAL_W-1:0];
    end

    a_merge_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.action == ACT_MERGE) |=> r_state == S_RDL)
        else $error("merge request did not start the read sequence");

    a_wr_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_MUL && $past(r_cnt) == 3'd4)
        else $error("parent write without completed products");

    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSUM && out_free) |=> (r_sum == '0 && r_out_valid
            && r_out_data <= ONE_Q15))
        else $error("finish did not clear sum or emit a clamped result");

endmodule
